FILE: hdl/glob_wildcard_matcher_configurable_defines.svh
// ----------------------------------------------------------------------------
// Glob matcher assertion macros
// Shared concurrent assertion shorthands for the glob wildcard matcher.
// ----------------------------------------------------------------------------
`ifndef GLOB_WILDCARD_MATCHER_CONFIGURABLE_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_CONFIGURABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GWM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("glob matcher assertion failed");

// Next-cycle implication, checked out of reset.
`define GWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("glob matcher assertion failed");

`endif

FILE: hdl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// Glob matcher package
// Token kinds, request function codes, configuration set and case folding.
// ----------------------------------------------------------------------------
package gwm_pkg;

	typedef enum logic [1:0] {
		KIND_LITERAL = 2'd0,
		KIND_SINGLE  = 2'd1,
		KIND_ANY_RUN = 2'd2
	} tok_kind_t;

	typedef enum logic [1:0] {
		FUNC_PAT_BYTE  = 2'd0,
		FUNC_PAT_END   = 2'd1,
		FUNC_TEXT_BYTE = 2'd2,
		FUNC_TEXT_END  = 2'd3
	} func_t;

	localparam logic [1:0] CFG_ANY_RUN_MARK = 2'd0;
	localparam logic [1:0] CFG_SINGLE_MARK  = 2'd1;
	localparam logic [1:0] CFG_ESCAPE_MARK  = 2'd2;
	localparam logic [1:0] CFG_FOLD_CASE    = 2'd3;

	localparam logic [7:0] RST_ANY_RUN_MARK = 8'd42;
	localparam logic [7:0] RST_SINGLE_MARK  = 8'd63;
	localparam logic [7:0] RST_ESCAPE_MARK  = 8'd92;

	typedef struct packed {
		logic [7:0] any_run_mark;
		logic [7:0] single_mark;
		logic [7:0] escape_mark;
		logic       fold_case;
	} cfg_t;

	// Token store write request from the loader to the cells.
	typedef struct packed {
		logic       wr;
		tok_kind_t  kind;
		logic [7:0] tbyte;
	} tok_wr_t;

	function automatic logic [7:0] fold(input logic fold_en, input logic [7:0] c);
		if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'd32;
		end
		return c;
	endfunction

endpackage

FILE: hdl/gwm_cell.sv
// ----------------------------------------------------------------------------
// Glob matcher cell
// Holds one token and the active bit of its position; hands the advance and
// any-run closure signals to the next cell.
// ----------------------------------------------------------------------------
module gwm_cell #(
	parameter int IDX = 0,
	parameter int IW  = 5,
	parameter int CW  = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gwm_pkg::tok_wr_t tok_wr,
	input  logic [IW-1:0]    wr_addr,
	input  logic [CW-1:0]    count,
	input  logic             fold_case,
	input  logic [7:0]       text_c,
	input  logic             text,
	input  logic             step,
	input  logic             adv_in,
	input  logic             run_in,
	output logic             adv_out,
	output logic             run_out,
	output logic             active
);

	gwm_pkg::tok_kind_t kind_q;
	logic [7:0]         byte_q;
	logic               active_q;
	logic               sel;
	logic               en;
	gwm_pkg::tok_kind_t kind_eff;
	logic               is_run;
	logic               consume;
	logic               closed;

	assign sel      = tok_wr.wr && (wr_addr == IW'(IDX));
	assign en       = CW'(IDX) < count;
	// A token written by the same commit already counts for the restart.
	assign kind_eff = sel ? tok_wr.kind : kind_q;
	assign is_run   = en && (kind_eff == gwm_pkg::KIND_ANY_RUN);

	always_comb begin
		case (kind_eff)
			gwm_pkg::KIND_SINGLE:  consume = 1'b1;
			gwm_pkg::KIND_LITERAL: consume = gwm_pkg::fold(fold_case, byte_q) == text_c;
			default:               consume = 1'b0;
		endcase
	end

	assign closed  = adv_in || run_in || (text && active_q && is_run);
	assign adv_out = text && active_q && en && consume;
	assign run_out = closed && is_run;
	assign active  = active_q;

	always_ff @(posedge clk) begin
		if (sel) begin
			kind_q <= tok_wr.kind;
			byte_q <= tok_wr.tbyte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'(IDX == 0);
		end else if (step) begin
			active_q <= closed;
		end
	end

endmodule

FILE: hdl/gwm_loader.sv
// ----------------------------------------------------------------------------
// Glob matcher pattern loader
// Turns pattern bytes into token store writes and yields the committed count.
// ----------------------------------------------------------------------------
module gwm_loader #(
	parameter int MAX_TOKENS = 32,
	parameter int IW         = 5,
	parameter int CW         = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gwm_pkg::cfg_t    cfg,
	input  logic             pat_byte,
	input  logic             pat_end,
	input  logic [7:0]       ch,
	output gwm_pkg::tok_wr_t tok_wr,
	output logic [IW-1:0]    wr_addr,
	output logic [CW-1:0]    commit_count,
	output logic             commit_ovf
);

	logic [CW-1:0]      cnt_q;
	logic               ovf_q;
	logic               esc_q;
	logic               last_q;
	logic               esc_d;
	logic               last_d;
	logic               add;
	gwm_pkg::tok_kind_t add_kind;
	logic [7:0]         add_byte;
	logic               full;

	always_comb begin
		add      = 1'b0;
		add_kind = gwm_pkg::KIND_LITERAL;
		add_byte = ch;
		esc_d    = esc_q;
		last_d   = last_q;
		if (pat_byte) begin
			if (esc_q) begin
				esc_d  = 1'b0;
				last_d = 1'b0;
				add    = 1'b1;
			end else if (cfg.any_run_mark != 8'd0 && ch == cfg.any_run_mark) begin
				add      = !last_q;
				add_kind = gwm_pkg::KIND_ANY_RUN;
				add_byte = 8'd0;
				last_d   = 1'b1;
			end else if (cfg.single_mark != 8'd0 && ch == cfg.single_mark) begin
				add      = 1'b1;
				add_kind = gwm_pkg::KIND_SINGLE;
				add_byte = 8'd0;
				last_d   = 1'b0;
			end else if (cfg.escape_mark != 8'd0 && ch == cfg.escape_mark) begin
				esc_d = 1'b1;
			end else begin
				add    = 1'b1;
				last_d = 1'b0;
			end
		end else if (pat_end && esc_q) begin
			// A dangling escape stands for itself.
			add      = 1'b1;
			add_byte = cfg.escape_mark;
		end
	end

	assign full         = cnt_q == CW'(MAX_TOKENS);
	assign tok_wr.wr    = add && !full;
	assign tok_wr.kind  = add_kind;
	assign tok_wr.tbyte = add_byte;
	assign wr_addr      = cnt_q[IW-1:0];
	assign commit_count = tok_wr.wr ? cnt_q + CW'(1) : cnt_q;
	assign commit_ovf   = ovf_q || (add && full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			esc_q  <= 1'b0;
			last_q <= 1'b0;
		end else if (pat_end) begin
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
			esc_q  <= 1'b0;
			last_q <= 1'b0;
		end else if (pat_byte) begin
			cnt_q  <= commit_count;
			ovf_q  <= commit_ovf;
			esc_q  <= esc_d;
			last_q <= last_d;
		end
	end

endmodule

FILE: hdl/glob_wildcard_matcher_configurable.sv
// ----------------------------------------------------------------------------
// Glob wildcard matcher, configurable marks
// Loads a glob pattern into a row of token cells and matches streamed text.
// ----------------------------------------------------------------------------
// A new request is taken in every cycle unless the input stalls: a pattern
// byte writes one token cell, an end of pattern commits the tokens and
// restarts matching, a text byte steps all positions at once, and an end of
// text puts a result in the output register, or in the skid slot while the
// output stalls. The cycle time is set by the any-run closure, which ripples
// through the row of MAX_TOKENS cells like the carry of an adder. A two-deep
// output stage keeps the input open while one result waits; only a second
// waiting result holds the input off. The token store needs no clearing after
// reset, since only positions below the committed count are ever consulted.
`include "glob_wildcard_matcher_configurable_defines.svh"

module glob_wildcard_matcher_configurable #(
	parameter int MAX_TOKENS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] func,
	input  logic [7:0] ch,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       matched,
	output logic       overflow
);

	localparam int IW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
	localparam int CW = $clog2(MAX_TOKENS + 1);

	gwm_pkg::cfg_t    cfg_q;
	gwm_pkg::func_t   f;
	gwm_pkg::tok_wr_t tok_wr;
	logic [IW-1:0]    wr_addr;
	logic [CW-1:0]    commit_count;
	logic             commit_ovf;
	logic [CW-1:0]    token_count_q;
	logic             pattern_ovf_q;
	logic [CW-1:0]    count_eff;
	logic             accept;
	logic             pat_byte;
	logic             pat_end;
	logic             text;
	logic             text_end;
	logic             restart;
	logic             step;
	logic [7:0]       text_c;
	logic [MAX_TOKENS:0]   adv;
	logic [MAX_TOKENS:0]   run;
	logic [MAX_TOKENS-1:0] act;
	logic             end_q;
	logic [MAX_TOKENS:0]   pos;
	logic             res_matched;
	logic             out_valid_q;
	logic             matched_q;
	logic             overflow_q;
	logic             skid_valid_q;
	logic             skid_matched_q;
	logic             skid_overflow_q;

	// Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.any_run_mark <= gwm_pkg::RST_ANY_RUN_MARK;
			cfg_q.single_mark  <= gwm_pkg::RST_SINGLE_MARK;
			cfg_q.escape_mark  <= gwm_pkg::RST_ESCAPE_MARK;
			cfg_q.fold_case    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				gwm_pkg::CFG_ANY_RUN_MARK: cfg_q.any_run_mark <= cfg_data;
				gwm_pkg::CFG_SINGLE_MARK:  cfg_q.single_mark  <= cfg_data;
				gwm_pkg::CFG_ESCAPE_MARK:  cfg_q.escape_mark  <= cfg_data;
				gwm_pkg::CFG_FOLD_CASE:    cfg_q.fold_case    <= cfg_data[0];
				default:                   cfg_q.fold_case    <= cfg_q.fold_case;
			endcase
		end
	end

	// The input closes only when both output slots hold results.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign f        = gwm_pkg::func_t'(func);
	assign pat_byte = accept && (f == gwm_pkg::FUNC_PAT_BYTE);
	assign pat_end  = accept && (f == gwm_pkg::FUNC_PAT_END);
	assign text     = accept && (f == gwm_pkg::FUNC_TEXT_BYTE);
	assign text_end = accept && (f == gwm_pkg::FUNC_TEXT_END);
	assign restart  = pat_end || text_end;
	assign step     = text || restart;
	assign text_c   = gwm_pkg::fold(cfg_q.fold_case, ch);

	gwm_loader #(
		.MAX_TOKENS(MAX_TOKENS),
		.IW(IW),
		.CW(CW)
	) u_loader (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pat_byte(pat_byte),
		.pat_end(pat_end),
		.ch(ch),
		.tok_wr(tok_wr),
		.wr_addr(wr_addr),
		.commit_count(commit_count),
		.commit_ovf(commit_ovf)
	);

	// A commit restarts against the new count in the same cycle.
	assign count_eff = pat_end ? commit_count : token_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_count_q <= '0;
			pattern_ovf_q <= 1'b0;
		end else if (pat_end) begin
			token_count_q <= commit_count;
			pattern_ovf_q <= commit_ovf;
		end
	end

	// A restart enters the row as an advance into position zero; the
	// closure over any-run tokens then ripples to the right.
	assign adv[0] = restart;
	assign run[0] = 1'b0;

	for (genvar i = 0; i < MAX_TOKENS; i++) begin : g_cell
		gwm_cell #(
			.IDX(i),
			.IW(IW),
			.CW(CW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_wr(tok_wr),
			.wr_addr(wr_addr),
			.count(count_eff),
			.fold_case(cfg_q.fold_case),
			.text_c(text_c),
			.text(text),
			.step(step),
			.adv_in(adv[i]),
			.run_in(run[i]),
			.adv_out(adv[i+1]),
			.run_out(run[i+1]),
			.active(act[i])
		);
	end

	// The last position has no token of its own and is only ever entered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q <= 1'b0;
		end else if (step) begin
			end_q <= adv[MAX_TOKENS] || run[MAX_TOKENS];
		end
	end

	assign pos         = {end_q, act};
	assign res_matched = !pattern_ovf_q && pos[token_count_q];

	// Output register with one skid slot behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= text_end;
			end
		end else if (text_end) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				matched_q  <= skid_matched_q;
				overflow_q <= skid_overflow_q;
			end else if (text_end) begin
				matched_q  <= res_matched;
				overflow_q <= pattern_ovf_q;
			end
		end else if (text_end) begin
			skid_matched_q  <= res_matched;
			skid_overflow_q <= pattern_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign overflow  = overflow_q;

	// The skid slot is only ever filled behind a full output register.
	`GWM_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	// A result arriving at a stalled, full output must land in the skid slot.
	`GWM_ASSERT_NEXT(a_skid_catches, clk, arst_n,
		text_end && out_valid_q && out_stall, skid_valid_q)
	// An overflowed pattern never reports a match.
	`GWM_ASSERT_IMPL(a_ovf_no_match, clk, arst_n, out_valid && overflow, !matched)
	// The committed count stays within the cell row.
	`GWM_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1,
		token_count_q <= CW'(MAX_TOKENS))

endmodule
